// ===== hw/rtl/assert_macros.svh =====
// assertion macros included by the rtl controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: expr");

// condition in one cycle implies expression in the next
`define ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("assertion failed: cond then expr");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_NEXT(label, clk, rst, cond, expr)

`endif

`endif

// ===== hw/rtl/pdz_pkg.sv =====
// shared constants, codes and controller/datapath types of the projector
`default_nettype none
package pdz_pkg;

  localparam int IMAGE_WIDTH  = 1280;
  localparam int IMAGE_HEIGHT = 1024;
  localparam int STORE_DEPTH  = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);

  localparam int COL_W   = 11;
  localparam int ROW_W   = 10;
  localparam int DEPTH_W = 16;
  localparam int WORD_W  = 32;
  localparam int CFG_INDEX_W = 4;

  // pixel index registers wide enough for ports and image size
  localparam int PCOL_W = ($clog2(IMAGE_WIDTH) > COL_W) ? $clog2(IMAGE_WIDTH) : COL_W;
  localparam int PROW_W = ($clog2(IMAGE_HEIGHT) > ROW_W) ? $clog2(IMAGE_HEIGHT) : ROW_W;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FOCAL_X  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FOCAL_Y  = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_K1       = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_K2       = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_P1       = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_P2       = 4'd7;

  // register reset values
  localparam logic [WORD_W-1:0] RST_FOCAL_X  = 32'd48953581;
  localparam logic [WORD_W-1:0] RST_FOCAL_Y  = 32'd48983240;
  localparam logic [WORD_W-1:0] RST_CENTER_X = 32'd43977264;
  localparam logic [WORD_W-1:0] RST_CENTER_Y = 32'd32388704;
  localparam logic [WORD_W-1:0] RST_K1       = 32'(-382784633);
  localparam logic [WORD_W-1:0] RST_K2       = 32'd169176958;
  localparam logic [WORD_W-1:0] RST_P1       = 32'(-324063);
  localparam logic [WORD_W-1:0] RST_P2       = 32'd536264;

  // iteration counts
  localparam int DIV_STEPS  = 31;
  localparam int SQRT_STEPS = 32;
  localparam int CNT_W      = 6;

  // multiplier operation codes, in issue order
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_SQ_X = 5'd0;
  localparam logic [OP_W-1:0] OP_SQ_Y = 5'd1;
  localparam logic [OP_W-1:0] OP_SQ_Z = 5'd2;
  localparam logic [OP_W-1:0] OP_UU   = 5'd3;
  localparam logic [OP_W-1:0] OP_VV   = 5'd4;
  localparam logic [OP_W-1:0] OP_UV   = 5'd5;
  localparam logic [OP_W-1:0] OP_RHO4 = 5'd6;
  localparam logic [OP_W-1:0] OP_K1R  = 5'd7;
  localparam logic [OP_W-1:0] OP_K2R  = 5'd8;
  localparam logic [OP_W-1:0] OP_UR   = 5'd9;
  localparam logic [OP_W-1:0] OP_P1X  = 5'd10;
  localparam logic [OP_W-1:0] OP_P2X  = 5'd11;
  localparam logic [OP_W-1:0] OP_VR   = 5'd12;
  localparam logic [OP_W-1:0] OP_P2Y  = 5'd13;
  localparam logic [OP_W-1:0] OP_P1Y  = 5'd14;
  localparam logic [OP_W-1:0] OP_FX   = 5'd15;
  localparam logic [OP_W-1:0] OP_FY   = 5'd16;
  localparam int N_OPS = 17;

  typedef struct packed {
    logic              load_item;
    logic              div_step;
    logic              mul_issue;
    logic              mul_lo;
    logic              mul_hi;
    logic              mul_done;
    logic [OP_W-1:0]   mul_op;
    logic              sqrt_load;
    logic              sqrt_step;
    logic              pix_load;
    logic              mem_rd;
    logic              mem_wr;
    logic              wr_zero;
    logic              res_load;
    logic              res_zero;
    logic              clr_wr;
    logic [ADDR_W-1:0] clr_addr;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic drop;
    logic range_ok;
    logic pix_off;
    logic lose;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/pdz_ram.sv =====
// generic simple dual port ram with registered read
`default_nettype none
module pdz_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/pdz_datapath.sv =====
// projector datapath: dividers, shared multiplier, square root, depth store
`default_nettype none
module pdz_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire pdz_pkg::cmd_t                     cmd,
  output pdz_pkg::status_t                       status,
  input  wire logic                              cfg_write,
  input  wire logic [pdz_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [pdz_pkg::WORD_W-1:0]        cfg_data,
  input  wire logic                              mode,
  input  wire logic signed [pdz_pkg::WORD_W-1:0] point_x,
  input  wire logic signed [pdz_pkg::WORD_W-1:0] point_y,
  input  wire logic signed [pdz_pkg::WORD_W-1:0] point_z,
  input  wire logic [pdz_pkg::COL_W-1:0]         read_col,
  input  wire logic [pdz_pkg::ROW_W-1:0]         read_row,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   kind,
  output logic [pdz_pkg::COL_W-1:0]              pixel_col,
  output logic [pdz_pkg::ROW_W-1:0]              pixel_row,
  output logic [pdz_pkg::DEPTH_W-1:0]            depth_whole,
  output logic [pdz_pkg::WORD_W-1:0]             distance
);
  import pdz_pkg::*;

  function automatic logic [63:0] mag64(input logic signed [63:0] a);
    logic [63:0] t;
    t = a;
    return t[63] ? (~t + 64'd1) : t;
  endfunction

  // configuration
  logic        [31:0] focal_x, focal_y, center_x, center_y;
  logic signed [31:0] k1, k2, p1, p2;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x  <= RST_FOCAL_X;
      focal_y  <= RST_FOCAL_Y;
      center_x <= RST_CENTER_X;
      center_y <= RST_CENTER_Y;
      k1 <= $signed(RST_K1);
      k2 <= $signed(RST_K2);
      p1 <= $signed(RST_P1);
      p2 <= $signed(RST_P2);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FOCAL_X:  focal_x  <= cfg_data;
        REG_FOCAL_Y:  focal_y  <= cfg_data;
        REG_CENTER_X: center_x <= cfg_data;
        REG_CENTER_Y: center_y <= cfg_data;
        REG_K1:       k1 <= $signed(cfg_data);
        REG_K2:       k2 <= $signed(cfg_data);
        REG_P1:       p1 <= $signed(cfg_data);
        REG_P2:       p2 <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // item capture
  logic [31:0] ax_in, ay_in, az_in;
  logic        drop_in;
  assign ax_in = point_x[31] ? (~point_x + 32'd1) : point_x;
  assign ay_in = point_y[31] ? (~point_y + 32'd1) : point_y;
  assign az_in = point_z[31] ? (~point_z + 32'd1) : point_z;
  // behind or on the camera plane, or quotient magnitude of 8 or more
  assign drop_in = point_z[31] || (point_z == 32'sd0)
                || ({3'b000, ax_in} >= {point_z, 3'b000})
                || ({3'b000, ay_in} >= {point_z, 3'b000});

  logic              mode_q, drop_q, sx, sy;
  logic [31:0]       ax, ay, az;
  logic [30:0]       dz;
  logic [31:0]       remx, remy;
  logic [30:0]       qx, qy, shx, shy;
  logic [PCOL_W-1:0] col_q;
  logic [PROW_W-1:0] row_q;
  logic              off_q;

  // restoring division, one quotient bit per step
  logic [32:0] trx, try_;
  assign trx  = {remx, shx[30]};
  assign try_ = {remy, shy[30]};

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      mode_q <= mode;
      drop_q <= drop_in;
      sx <= point_x[31];
      sy <= point_y[31];
      ax <= ax_in;
      ay <= ay_in;
      az <= az_in;
      dz <= point_z[30:0];
      remx <= {3'b000, ax_in[31:3]};
      remy <= {3'b000, ay_in[31:3]};
      shx  <= {ax_in[2:0], 28'd0};
      shy  <= {ay_in[2:0], 28'd0};
      qx <= '0;
      qy <= '0;
    end else if (cmd.div_step) begin
      shx <= {shx[29:0], 1'b0};
      shy <= {shy[29:0], 1'b0};
      if (trx >= {2'b00, dz}) begin
        remx <= 32'(trx - {2'b00, dz});
        qx   <= {qx[29:0], 1'b1};
      end else begin
        remx <= trx[31:0];
        qx   <= {qx[29:0], 1'b0};
      end
      if (try_ >= {2'b00, dz}) begin
        remy <= 32'(try_ - {2'b00, dz});
        qy   <= {qy[29:0], 1'b1};
      end else begin
        remy <= try_[31:0];
        qy   <= {qy[29:0], 1'b0};
      end
    end
  end

  logic signed [63:0] u_w, v_w;
  assign u_w = sx ? -$signed({33'd0, qx}) : $signed({33'd0, qx});
  assign v_w = sy ? -$signed({33'd0, qy}) : $signed({33'd0, qy});

  // products, each written by its own operation
  logic signed [63:0] prod [N_OPS];
  logic signed [63:0] rho2, tx_w, ty_w, rad, du, dv;
  assign rho2 = prod[OP_UU] + prod[OP_VV];
  assign tx_w = rho2 + (prod[OP_UU] <<< 1);
  assign ty_w = rho2 + (prod[OP_VV] <<< 1);
  assign rad  = 64'sd268435456 + prod[OP_K1R] + prod[OP_K2R];
  assign du   = prod[OP_UR] + prod[OP_P1X] + prod[OP_P2X];
  assign dv   = prod[OP_VR] + prod[OP_P2Y] + prod[OP_P1Y];

  logic signed [63:0] op_a, op_b;
  logic        [4:0]  op_sh;
  always_comb begin
    op_a  = '0;
    op_b  = '0;
    op_sh = 5'd28;
    unique case (cmd.mul_op)
      OP_SQ_X: begin op_a = $signed({32'd0, ax}); op_b = $signed({32'd0, ax}); op_sh = 5'd0; end
      OP_SQ_Y: begin op_a = $signed({32'd0, ay}); op_b = $signed({32'd0, ay}); op_sh = 5'd0; end
      OP_SQ_Z: begin op_a = $signed({32'd0, az}); op_b = $signed({32'd0, az}); op_sh = 5'd0; end
      OP_UU:   begin op_a = u_w;  op_b = u_w; end
      OP_VV:   begin op_a = v_w;  op_b = v_w; end
      OP_UV:   begin op_a = u_w;  op_b = v_w; end
      OP_RHO4: begin op_a = rho2; op_b = rho2; end
      OP_K1R:  begin op_a = 64'(k1); op_b = rho2;          op_sh = 5'd30; end
      OP_K2R:  begin op_a = 64'(k2); op_b = prod[OP_RHO4]; op_sh = 5'd30; end
      OP_UR:   begin op_a = u_w;  op_b = rad; end
      OP_P1X:  begin op_a = 64'(p1); op_b = prod[OP_UV]; op_sh = 5'd29; end
      OP_P2X:  begin op_a = 64'(p2); op_b = tx_w;        op_sh = 5'd30; end
      OP_VR:   begin op_a = v_w;  op_b = rad; end
      OP_P2Y:  begin op_a = 64'(p2); op_b = prod[OP_UV]; op_sh = 5'd29; end
      OP_P1Y:  begin op_a = 64'(p1); op_b = ty_w;        op_sh = 5'd30; end
      OP_FX:   begin op_a = $signed({32'd0, focal_x}); op_b = du; end
      OP_FY:   begin op_a = $signed({32'd0, focal_y}); op_b = dv; end
      default: ;
    endcase
  end

  // shared multiplier: 36 x 32 partial products, low half of the operand then high half
  logic [63:0]  mag_a, mag_b;
  logic [35:0]  ma;
  logic [63:0]  mb;
  logic         mneg;
  logic [4:0]   msh;
  logic [99:0]  acc, shifted;
  logic [67:0]  pp;
  logic [31:0]  mb_half;
  logic [63:0]  res_mag, res;

  assign mag_a   = mag64(op_a);
  assign mag_b   = mag64(op_b);
  assign mb_half = cmd.mul_hi ? mb[63:32] : mb[31:0];
  assign pp      = ma * mb_half;
  assign shifted = acc >> msh;
  assign res_mag = shifted[63:0];
  assign res     = mneg ? (~res_mag + 64'd1) : res_mag;

  always_ff @(posedge clk) begin
    if (cmd.mul_issue) begin
      ma   <= mag_a[35:0];
      mb   <= mag_b;
      mneg <= op_a[63] ^ op_b[63];
      msh  <= op_sh;
    end
    if (cmd.mul_lo) begin
      acc <= 100'(pp);
    end else if (cmd.mul_hi) begin
      acc <= acc + {pp, 32'd0};
    end
    if (cmd.mul_done) begin
      prod[cmd.mul_op] <= $signed(res);
    end
  end

  // digit by digit square root of the squared distance
  logic [63:0] sq_sum, sn, sr, sbit, trial;
  assign sq_sum = prod[OP_SQ_X] + prod[OP_SQ_Y] + prod[OP_SQ_Z];
  assign trial  = sr + sbit;

  always_ff @(posedge clk) begin
    if (cmd.sqrt_load) begin
      sn   <= sq_sum;
      sr   <= '0;
      sbit <= 64'd1 << 62;
    end else if (cmd.sqrt_step) begin
      if (sn >= trial) begin
        sn <= sn - trial;
        sr <= (sr >> 1) + sbit;
      end else begin
        sr <= sr >> 1;
      end
      sbit <= sbit >> 2;
    end
  end

  logic [31:0] dist_q16;
  assign dist_q16 = sr[31:0];

  // pixel positions, truncated toward zero
  logic signed [63:0] posx, posy;
  logic        [47:0] wholex, wholey;
  logic               offx, offy;
  assign posx   = prod[OP_FX] + $signed({32'd0, center_x});
  assign posy   = prod[OP_FY] + $signed({32'd0, center_y});
  assign wholex = posx[63] ? 48'd0 : posx[63:16];
  assign wholey = posy[63] ? 48'd0 : posy[63:16];
  assign offx   = (posx <= -64'sd65536) || (wholex >= 48'(IMAGE_WIDTH));
  assign offy   = (posy <= -64'sd65536) || (wholey >= 48'(IMAGE_HEIGHT));

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      col_q <= PCOL_W'(read_col);
      row_q <= PROW_W'(read_row);
    end else if (cmd.pix_load) begin
      col_q <= wholex[PCOL_W-1:0];
      row_q <= wholey[PROW_W-1:0];
      off_q <= offx || offy;
    end
  end

  // depth store
  logic [ADDR_W-1:0]  addr_w, addr_q;
  logic [DEPTH_W-1:0] rd_data, wr_data, res_depth;
  logic               wr_en;

  assign addr_w  = ADDR_W'(32'(row_q) * IMAGE_WIDTH + 32'(col_q));
  assign wr_en   = cmd.mem_wr || cmd.clr_wr;
  assign wr_data = (cmd.clr_wr || cmd.wr_zero) ? '0 : dist_q16[31:16];

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      addr_q <= addr_w;
    end
  end

  pdz_ram #(
    .WIDTH(DEPTH_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(cmd.clr_wr ? cmd.clr_addr : addr_q),
    .wr_data(wr_data),
    .rd_en  (cmd.mem_rd),
    .rd_addr(addr_w),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_depth <= cmd.res_zero ? '0 : (mode_q ? rd_data : dist_q16[31:16]);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      kind        <= mode_q;
      pixel_col   <= col_q[COL_W-1:0];
      pixel_row   <= row_q[ROW_W-1:0];
      depth_whole <= res_depth;
      distance    <= mode_q ? '0 : dist_q16;
    end
  end

  assign status.is_read  = mode_q;
  assign status.drop     = drop_q;
  assign status.range_ok = (32'(col_q) < 32'(IMAGE_WIDTH)) && (32'(row_q) < 32'(IMAGE_HEIGHT));
  assign status.pix_off  = off_q;
  assign status.lose     = (rd_data != '0) && ({rd_data, 16'd0} <= dist_q16);
  assign status.out_free = !out_valid || !out_stall;

endmodule
`default_nettype wire

// ===== hw/rtl/pdz_ctrl.sv =====
// projector controller: item sequencing, operation issue, store clearing
`default_nettype none
`include "assert_macros.svh"
module pdz_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire pdz_pkg::status_t status,
  output pdz_pkg::cmd_t         cmd
);
  import pdz_pkg::*;

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_CHECK  = 4'd2;
  localparam logic [3:0] ST_RDDATA = 4'd3;
  localparam logic [3:0] ST_DIV    = 4'd4;
  localparam logic [3:0] ST_ISSUE  = 4'd5;
  localparam logic [3:0] ST_LO     = 4'd6;
  localparam logic [3:0] ST_HI     = 4'd7;
  localparam logic [3:0] ST_DONE   = 4'd8;
  localparam logic [3:0] ST_PIX    = 4'd9;
  localparam logic [3:0] ST_LOOKUP = 4'd10;
  localparam logic [3:0] ST_CMP    = 4'd11;
  localparam logic [3:0] ST_EMIT   = 4'd12;

  logic [3:0]        state, state_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [CNT_W-1:0]  sqrt_cnt, sqrt_cnt_next;
  logic [OP_W-1:0]   op, op_next;
  logic [ADDR_W-1:0] clr_addr, clr_addr_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    op_next       = op;
    clr_addr_next = clr_addr;
    sqrt_cnt_next = sqrt_cnt;
    cmd           = '0;
    cmd.mul_op    = op;
    cmd.clr_addr  = clr_addr;

    unique case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end else begin
          clr_addr_next = clr_addr + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.is_read) begin
          if (status.range_ok) begin
            cmd.mem_rd = 1'b1;
            state_next = ST_RDDATA;
          end else begin
            cmd.res_load = 1'b1;
            cmd.res_zero = 1'b1;
            state_next   = ST_EMIT;
          end
        end else if (status.drop) begin
          state_next = ST_IDLE;
        end else begin
          cnt_next   = '0;
          state_next = ST_DIV;
        end
      end
      ST_RDDATA: begin
        cmd.res_load = 1'b1;
        cmd.mem_wr   = 1'b1;
        cmd.wr_zero  = 1'b1;
        state_next   = ST_EMIT;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          cnt_next   = '0;
          op_next    = OP_SQ_X;
          state_next = ST_ISSUE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_ISSUE: begin
        cmd.mul_issue = 1'b1;
        // squares are in place once the first distortion product issues
        cmd.sqrt_load = (op == OP_UU);
        state_next    = ST_LO;
      end
      ST_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = ST_HI;
      end
      ST_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        cmd.mul_done = 1'b1;
        if (op == OP_FY) begin
          state_next = ST_PIX;
        end else begin
          op_next    = op + 1'b1;
          state_next = ST_ISSUE;
        end
      end
      ST_PIX: begin
        if (sqrt_cnt == '0) begin
          cmd.pix_load = 1'b1;
          state_next   = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (status.pix_off) begin
          state_next = ST_IDLE;
        end else begin
          cmd.mem_rd = 1'b1;
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        if (status.lose) begin
          state_next = ST_IDLE;
        end else begin
          cmd.mem_wr   = 1'b1;
          cmd.res_load = 1'b1;
          state_next   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // square root runs beside the multiplier sequence
    if (cmd.sqrt_load) begin
      sqrt_cnt_next = CNT_W'(SQRT_STEPS);
    end else if (sqrt_cnt != '0) begin
      cmd.sqrt_step = 1'b1;
      sqrt_cnt_next = sqrt_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      cnt      <= '0;
      sqrt_cnt <= '0;
      op       <= '0;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      sqrt_cnt <= sqrt_cnt_next;
      op       <= op_next;
      clr_addr <= clr_addr_next;
    end
  end

  `ASSERT_ALWAYS(a_sqrt_done_at_lookup, clk, rst, (state != ST_LOOKUP) || (sqrt_cnt == '0))
  `ASSERT_ALWAYS(a_store_one_access, clk, rst, !(cmd.mem_rd && (cmd.mem_wr || cmd.clr_wr)))
  `ASSERT_NEXT(a_accept_to_check, clk, rst, (in_valid && !in_stall), (state == ST_CHECK))

endmodule
`default_nettype wire

// ===== hw/rtl/pinhole_distort_zbuffer_projector_unit.sv =====
// top level of the pinhole projector with lens distortion and depth store
// a point passes from transfer to result through 31 divide steps, 17 shared multiplies,
//   then store read, compare, write
// throughput: one item in flight; next transfer taken once the previous item ends
// reset: synchronous; registers take defaults, then a clearing pass over all
//   IMAGE_WIDTH*IMAGE_HEIGHT addresses (1310720) zeroes the store with input stalled
`default_nettype none
module pinhole_distort_zbuffer_projector_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration writes
  input  wire logic                              cfg_write,
  input  wire logic [pdz_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [pdz_pkg::WORD_W-1:0]        cfg_data,
  // input items
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              mode,
  input  wire logic signed [pdz_pkg::WORD_W-1:0] point_x,
  input  wire logic signed [pdz_pkg::WORD_W-1:0] point_y,
  input  wire logic signed [pdz_pkg::WORD_W-1:0] point_z,
  input  wire logic [pdz_pkg::COL_W-1:0]         read_col,
  input  wire logic [pdz_pkg::ROW_W-1:0]         read_row,
  // result items
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   kind,
  output logic [pdz_pkg::COL_W-1:0]              pixel_col,
  output logic [pdz_pkg::ROW_W-1:0]              pixel_row,
  output logic [pdz_pkg::DEPTH_W-1:0]            depth_whole,
  output logic [pdz_pkg::WORD_W-1:0]             distance
);
  import pdz_pkg::*;

  // command and status between sequencer and datapath
  cmd_t    cmd;
  status_t status;

  // sequencer: clearing pass, item flow, multiply schedule
  pdz_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  // datapath: the output register lets a finished result wait for its transfer
  // while the next item is already taken in
  pdz_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mode       (mode),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .read_col   (read_col),
    .read_row   (read_row),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .pixel_col  (pixel_col),
    .pixel_row  (pixel_row),
    .depth_whole(depth_whole),
    .distance   (distance)
  );

endmodule
`default_nettype wire
